// ----- hw/rtl/rcfe_pkg.sv -----
package rcfe_pkg;

    localparam int CHAN_W      = 16;
    localparam int VAL_W       = 11;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int IDX_W       = 4;
    localparam int ACC_W       = PEND_W + VAL_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY       = 8'hD5;
    localparam logic [BYTE_W-1:0] FRAME_LEN_BYTE = 8'd24;
    localparam logic [IDX_W-1:0]  LAST_CHANNEL   = 4'd15;
    localparam logic [PCNT_W-1:0] TWO_BYTE_CNT   = 3'd5;
    localparam logic [PCNT_W-1:0] ONE_BYTE_ADD   = 3'd3;

    localparam logic [BYTE_W-1:0]     RST_DEST  = 8'd200;
    localparam logic [BYTE_W-1:0]     RST_TYPE  = 8'd22;
    localparam logic [VAL_W-1:0]      RST_MIN   = 11'd172;
    localparam logic [VAL_W-1:0]      RST_MAX   = 11'd1811;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST = 2'd0,
        CFG_TYPE = 2'd1,
        CFG_MIN  = 2'd2,
        CFG_MAX  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] ftype;
        logic [VAL_W-1:0]  ch_min;
        logic [VAL_W-1:0]  ch_max;
    } t_cfg;

    // one channel worth of work for the byte sequencer
    typedef struct packed {
        logic              first;
        logic              last;
        logic              two;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
    } t_job;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ADDR = 7'b0000010,
        S_LEN  = 7'b0000100,
        S_TYPE = 7'b0001000,
        S_D0   = 7'b0010000,
        S_D1   = 7'b0100000,
        S_CRC  = 7'b1000000
    } t_step;

    function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/rcfe_chan_if.sv -----
interface rcfe_chan_if;
    logic        valid;
    logic        ready;
    logic [15:0] channel_value;

    modport source (output valid, output channel_value, input ready);
    modport sink (input valid, input channel_value, output ready);
endinterface

// ----- hw/rtl/rcfe_byte_if.sv -----
interface rcfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_last;

    modport source (output valid, output out_byte, output frame_last, input ready);
    modport sink (input valid, input out_byte, input frame_last, output ready);
endinterface

// ----- hw/rtl/rcfe_front.sv -----
module rcfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcfe_pkg::t_cfg    i_cfg,
    rcfe_chan_if.sink         i_chan,
    input  logic              i_q_full,
    output logic              o_push,
    output rcfe_pkg::t_job    o_job
);
    import rcfe_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic [PEND_W-1:0] r_pend;
    logic [PCNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]  n_idx;
    logic [PEND_W-1:0] n_pend;
    logic [PCNT_W-1:0] n_cnt;

    logic              first;
    logic              last;
    logic              two;
    logic [CHAN_W-1:0] lo_clamp;
    logic [CHAN_W-1:0] hi_clamp;
    logic [VAL_W-1:0]  val;
    logic [PEND_W-1:0] pend;
    logic [PCNT_W-1:0] cnt;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  rest;

    assign i_chan.ready = !i_q_full;
    assign o_push       = i_chan.valid && !i_q_full;

    always_comb begin
        first    = (r_idx == '0);
        last     = (r_idx == LAST_CHANNEL);
        pend     = first ? '0 : r_pend;
        cnt      = first ? '0 : r_cnt;
        // raise to min, then lower to max
        lo_clamp = (i_chan.channel_value < CHAN_W'(i_cfg.ch_min)) ?
                   CHAN_W'(i_cfg.ch_min) : i_chan.channel_value;
        hi_clamp = (lo_clamp > CHAN_W'(i_cfg.ch_max)) ? CHAN_W'(i_cfg.ch_max) : lo_clamp;
        val      = hi_clamp[VAL_W-1:0];
        acc      = ACC_W'(pend) | (ACC_W'(val) << cnt);
        two      = (cnt >= TWO_BYTE_CNT);
        rest     = two ? (acc >> 16) : (acc >> 8);
        n_idx    = r_idx + 1'b1;
        n_pend   = last ? '0 : rest[PEND_W-1:0];
        n_cnt    = last ? '0 : (two ? (cnt - TWO_BYTE_CNT) : (cnt + ONE_BYTE_ADD));
        o_job.first = first;
        o_job.last  = last;
        o_job.two   = two;
        o_job.byte0 = acc[7:0];
        o_job.byte1 = acc[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (o_push) begin
            r_idx  <= n_idx;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/rcfe_queue.sv -----
module rcfe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rcfe_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output rcfe_pkg::t_job    o_job
);
    import rcfe_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");

endmodule

// ----- hw/rtl/rcfe_back.sv -----
module rcfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcfe_pkg::t_cfg    i_cfg,
    input  logic              i_head_valid,
    input  rcfe_pkg::t_job    i_head,
    output logic              o_pop,
    rcfe_byte_if.source       o_frame
);
    import rcfe_pkg::*;

    t_step             r_step;
    t_step             n_step;
    t_step             cur;
    logic [BYTE_W-1:0] r_crc;
    logic [BYTE_W-1:0] n_crc;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [BYTE_W-1:0] n_byte;
    logic              n_last;
    logic              out_free;
    logic              fire;

    assign out_free         = !r_valid || o_frame.ready;
    assign fire             = i_head_valid && out_free;
    assign o_pop            = fire && (n_step == S_IDLE);
    assign o_frame.valid    = r_valid;
    assign o_frame.out_byte = r_byte;
    assign o_frame.frame_last = r_last;

    always_comb begin
        cur = (r_step == S_IDLE) ? (i_head.first ? S_ADDR : S_D0) : r_step;
        n_byte = '0;
        n_last = 1'b0;
        n_crc  = r_crc;
        n_step = S_IDLE;
        unique case (cur)
            S_ADDR: begin
                n_byte = i_cfg.dest;
                n_step = S_LEN;
            end
            S_LEN: begin
                n_byte = FRAME_LEN_BYTE;
                n_step = S_TYPE;
            end
            S_TYPE: begin
                n_byte = i_cfg.ftype;
                n_crc  = crc_update('0, i_cfg.ftype);
                n_step = S_D0;
            end
            S_D0: begin
                n_byte = i_head.byte0;
                n_crc  = crc_update(r_crc, i_head.byte0);
                n_step = i_head.two ? S_D1 : (i_head.last ? S_CRC : S_IDLE);
            end
            S_D1: begin
                n_byte = i_head.byte1;
                n_crc  = crc_update(r_crc, i_head.byte1);
                n_step = i_head.last ? S_CRC : S_IDLE;
            end
            S_CRC: begin
                n_byte = r_crc;
                n_last = 1'b1;
                n_crc  = '0;
                n_step = S_IDLE;
            end
            default: begin
                n_step = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_IDLE;
            r_crc   <= '0;
            r_valid <= 1'b0;
        end else if (fire) begin
            r_step  <= n_step;
            r_crc   <= n_crc;
            r_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    a_crc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && cur == S_CRC) |=> (r_crc == '0 && r_step == S_IDLE))
        else $error("crc not cleared after frame end");
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_last) |-> o_pop) else $error("frame end without job release");
    a_step_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_IDLE) |-> i_head_valid) else $error("job lost mid sequence");

endmodule

// ----- hw/rtl/rc_channel_frame_encoder.sv -----
// channel   | dir | handshake           | payload
// i_chan    | in  | valid/ready         | channel_value[15:0]
// o_frame   | out | valid/ready         | out_byte[7:0], frame_last
// i_cfg_*   | in  | write enable only   | index[1:0], data[10:0]
//
// an item is taken in any cycle in which the four-entry job queue has room
// the byte sequencer sends one byte per cycle unless o_frame stalls: for a frame's
// first item address, length, type, one data byte; else one or two data bytes, then
// CRC after the last; 16 items make 26 bytes, so back-to-back items fill the queue,
// as do output stalls; then i_chan.ready drops until the sequencer frees an entry
// synchronous active-low reset clears the config to defaults and starts a new frame
module rc_channel_frame_encoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rcfe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rcfe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rcfe_chan_if.sink                          i_chan,
    rcfe_byte_if.source                        o_frame
);
    import rcfe_pkg::*;

    t_cfg r_cfg;
    logic q_full;
    logic push;
    t_job push_job;
    logic pop;
    logic head_valid;
    t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest   <= RST_DEST;
            r_cfg.ftype  <= RST_TYPE;
            r_cfg.ch_min <= RST_MIN;
            r_cfg.ch_max <= RST_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEST: r_cfg.dest   <= i_cfg_data[BYTE_W-1:0];
                CFG_TYPE: r_cfg.ftype  <= i_cfg_data[BYTE_W-1:0];
                CFG_MIN:  r_cfg.ch_min <= i_cfg_data[VAL_W-1:0];
                CFG_MAX:  r_cfg.ch_max <= i_cfg_data[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rcfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_chan   (i_chan),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    rcfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    rcfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_frame      (o_frame)
    );

endmodule
